// ----- hw/rtl/text_console_writer_defines.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("text console writer: property violated");
`define TCW_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("text console writer: forbidden condition seen");
`else
`define TCW_ASSERT(label, prop)
`define TCW_ASSERT_NEVER(label, expr)
`endif
`endif

// ----- hw/rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, cell constants, operation codes and transfer types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = 11;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;

	localparam logic [ADDR_W-1:0] CELLS_A     = ADDR_W'(CELLS);
	localparam logic [ADDR_W-1:0] LAST_CELL_A = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COLUMNS_A   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_BASE_A = ADDR_W'(CELLS - COLUMNS);
	localparam logic [COL_W-1:0]  COLUMNS_C   = COL_W'(COLUMNS);

	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]        NEWLINE_BYTE = 8'd10;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_BACK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  character;
		logic [7:0]  color;
		logic [10:0] cell_address;
	} item_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_value;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode terminal engine holding an 80x25 screen store and a cursor.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows with done high for a single cycle, and it cannot be held off. A put
// that does not scroll, or a backspace, returns its result in the next cycle
// and busy stays low, so one command per cycle is sustained. A cell read within
// the screen passes through S_READ because of the registered read of the screen
// memory; one beyond it is answered from idle with a zero cell value. Clear
// screen sweeps the single memory write port over every cell. A line feed past
// the bottom row, or a put that wraps past it, scrolls: a copy pass of
// CELLS - COLUMNS cells, one per cycle, then a blank pass of the bottom row,
// after which a wrapping put writes its character. After reset the block is
// busy while it blanks the store, and gives no result for that pass.
`default_nettype none

`include "text_console_writer_defines.svh"

module text_console_writer
	import tcw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire item_t   item,
	output logic         busy,
	output logic         done,
	output result_t      result
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_SCROLL = 5'b00100,
		S_BLANK  = 5'b01000,
		S_PUTW   = 5'b10000
	} state_t;

	logic [CELL_W-1:0] mem [CELLS];

	state_t            state_q, state_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [ADDR_W-1:0] src_q, src_d;
	logic              emit_q, emit_d;
	logic              putw_q, putw_d;
	logic [7:0]        char_q;
	logic [7:0]        color_q;
	logic              load_pay;

	logic              cp_vld_s1, cp_vld_d;
	logic [ADDR_W-1:0] cp_dst_s1;
	logic [CELL_W-1:0] rd_data_s1;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	logic              done_q, done_d;
	result_t           result_q;
	logic [CELL_W-1:0] cell_d;
	logic [ADDR_W-1:0] pos_d;
	logic [ADDR_W-1:0] cur_addr;

	assign cur_addr = base_q + {{(ADDR_W-COL_W){1'b0}}, col_q};

	always_comb begin
		state_d  = state_q;
		col_d    = col_q;
		base_d   = base_q;
		ptr_d    = ptr_q;
		src_d    = src_q;
		emit_d   = emit_q;
		putw_d   = putw_q;
		load_pay = 1'b0;
		cp_vld_d = 1'b0;
		we       = 1'b0;
		waddr    = cur_addr;
		wdata    = BLANK_CELL;
		re       = 1'b0;
		raddr    = item.cell_address;
		done_d   = 1'b0;
		cell_d   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (item.op)
						OP_PUT: begin
							if (item.character == NEWLINE_BYTE) begin
								if (base_q == LAST_BASE_A) begin
									state_d = S_SCROLL;
									src_d   = COLUMNS_A;
									base_d  = LAST_BASE_A;
									col_d   = '0;
									emit_d  = 1'b1;
									putw_d  = 1'b0;
								end else begin
									base_d = base_q + COLUMNS_A;
									col_d  = '0;
									done_d = 1'b1;
								end
							end else if (col_q >= COLUMNS_C) begin
								if (base_q == LAST_BASE_A) begin
									state_d  = S_SCROLL;
									src_d    = COLUMNS_A;
									base_d   = LAST_BASE_A;
									col_d    = '0;
									emit_d   = 1'b1;
									putw_d   = 1'b1;
									load_pay = 1'b1;
								end else begin
									base_d = base_q + COLUMNS_A;
									col_d  = COL_W'(1);
									we     = 1'b1;
									waddr  = base_q + COLUMNS_A;
									wdata  = {item.color, item.character};
									done_d = 1'b1;
								end
							end else begin
								col_d  = col_q + COL_W'(1);
								we     = 1'b1;
								wdata  = {item.color, item.character};
								done_d = 1'b1;
							end
						end
						OP_BACK: begin
							if (col_q != '0) begin
								col_d = col_q - COL_W'(1);
								we    = 1'b1;
								waddr = cur_addr - ADDR_W'(1);
							end
							done_d = 1'b1;
						end
						OP_CLEAR: begin
							state_d = S_BLANK;
							ptr_d   = '0;
							col_d   = '0;
							base_d  = '0;
							emit_d  = 1'b1;
							putw_d  = 1'b0;
						end
						OP_READ: begin
							if (item.cell_address < CELLS_A) begin
								re      = 1'b1;
								state_d = S_READ;
							end else begin
								done_d = 1'b1;
							end
						end
					endcase
				end
			end
			S_READ: begin
				done_d  = 1'b1;
				cell_d  = rd_data_s1;
				state_d = S_IDLE;
			end
			S_SCROLL: begin
				if (src_q < CELLS_A) begin
					re       = 1'b1;
					raddr    = src_q;
					src_d    = src_q + ADDR_W'(1);
					cp_vld_d = 1'b1;
				end else if (!cp_vld_s1) begin
					state_d = S_BLANK;
					ptr_d   = LAST_BASE_A;
				end
				if (cp_vld_s1) begin
					we    = 1'b1;
					waddr = cp_dst_s1;
					wdata = rd_data_s1;
				end
			end
			S_BLANK: begin
				we    = 1'b1;
				waddr = ptr_q;
				if (ptr_q == LAST_CELL_A) begin
					if (putw_q) begin
						state_d = S_PUTW;
					end else begin
						state_d = S_IDLE;
						done_d  = emit_q;
					end
				end else begin
					ptr_d = ptr_q + ADDR_W'(1);
				end
			end
			S_PUTW: begin
				we      = 1'b1;
				wdata   = {color_q, char_q};
				col_d   = col_q + COL_W'(1);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		pos_d = base_d + {{(ADDR_W-COL_W){1'b0}}, col_d};
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		cp_dst_s1 <= src_q - COLUMNS_A;
		if (load_pay) begin
			char_q  <= item.character;
			color_q <= item.color;
		end
		if (done_d) begin
			result_q.cursor_pos <= pos_d;
			result_q.cell_value <= cell_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_BLANK;
			col_q     <= '0;
			base_q    <= '0;
			ptr_q     <= '0;
			src_q     <= '0;
			emit_q    <= 1'b0;
			putw_q    <= 1'b0;
			cp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			col_q     <= col_d;
			base_q    <= base_d;
			ptr_q     <= ptr_d;
			src_q     <= src_d;
			emit_q    <= emit_d;
			putw_q    <= putw_d;
			cp_vld_s1 <= cp_vld_d;
			done_q    <= done_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// The cursor column may rest one past the last cell of a row, never further.
	`TCW_ASSERT_NEVER(a_col_range, col_q > COLUMNS_C)
	`TCW_ASSERT_NEVER(a_base_range, base_q > LAST_BASE_A)
	// A copy write is still in flight, so the scroll pass must not have ended.
	`TCW_ASSERT(a_copy_in_scroll, cp_vld_s1 |-> state_q == S_SCROLL)
	`TCW_ASSERT(a_clear_sweeps, (state_q == S_IDLE && start && item.op == OP_CLEAR) |=> state_q == S_BLANK)
	`TCW_ASSERT_NEVER(a_pos_range, done_q && result_q.cursor_pos > CELLS_A)

endmodule

`default_nettype wire
